@@ hw/rtl/swm_pkg.sv @@
// Shared constants and types for the sliding-window median filter.
package swm_pkg;

  // Default window capacity and sample width
  localparam int WINDOW_MAX_DEF   = 32;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Window size register width and its value after reset
  localparam int          CFG_W        = 6;
  localparam logic [5:0]  WINDOW_RESET = 6'd3;

  // Control from the top level to the cell array
  typedef struct packed {
    logic step;   // insert one sample this cycle
    logic flush;  // empty the window
  } swm_cell_ctl_t;

endpackage

@@ hw/rtl/swm_sample_if.sv @@
// Input channel: one signed sample per item with valid/ready handshake.
interface swm_sample_if #(
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ hw/rtl/swm_result_if.sv @@
// Result channel: twice the window median per item with valid/ready handshake.
interface swm_result_if #(
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SAMPLE_WIDTH:0] median_doubled;

  modport source (output valid, output median_doubled, input ready);
  modport sink   (input valid, input median_doubled, output ready);
endinterface

@@ hw/rtl/sliding_window_median_top.sv @@
// Top level of the sliding-window median filter.
// Running median over the last W signed samples, W set by cfg_wdata (0 acts as 1,
// values above WINDOW_MAX act as WINDOW_MAX, 3 after reset). The block takes one
// item per clock unless stalled; throughput is set by the sorted cell array, which
// removes the oldest sample and inserts the new one. A sample passes the input
// register and the cell array before its result reaches the output register. After
// reset or a write to the window register the window is empty, and the first W-1
// samples give no result; each sample after that gives twice the median (the sum
// of the two middle values for an even W). No clearing pass is needed after reset.
module sliding_window_median_top #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  swm_sample_if.sink                 in_ch,
  swm_result_if.source               out_ch,
  input  logic                       cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]  cfg_wdata
);
  import swm_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_MAX + 1);

  logic [CFG_W-1:0]               window_r;
  logic [FILL_W-1:0]              win_eff;
  logic                           s1_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample_r;
  logic                           s2_ready;
  logic                           in_rdy;
  logic                           result;
  swm_cell_ctl_t                  cell_ctl;
  logic signed [SAMPLE_WIDTH-1:0] vals [WINDOW_MAX];

  // Window length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_r <= cfg_wdata;
    end
  end

  // Clamp the window length into one to WINDOW_MAX
  always_comb begin
    if (window_r == '0) begin
      win_eff = FILL_W'(1);
    end else if (int'(window_r) > WINDOW_MAX) begin
      win_eff = FILL_W'(WINDOW_MAX);
    end else begin
      win_eff = FILL_W'(window_r);
    end
  end

  // Input register: advance when the cell array can take the item
  assign in_rdy      = !s1_valid_r || s2_ready;
  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_rdy) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      s1_sample_r <= in_ch.sample;
    end
  end

  assign cell_ctl.step  = s1_valid_r && s2_ready;
  assign cell_ctl.flush = cfg_we;

  swm_cells #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_cells (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (cell_ctl),
    .sample_i (s1_sample_r),
    .win_i    (win_eff),
    .vals_o   (vals),
    .result_o (result)
  );

  swm_median #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_median (
    .clk     (clk),
    .rst_n   (rst_n),
    .vals_i  (vals),
    .win_i   (win_eff),
    .take_i  (result),
    .ready_o (s2_ready),
    .out_ch  (out_ch)
  );

  // A held item keeps its sample while the cell array is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(s1_sample_r)))
    else $error("input register dropped a stalled item");

  // The clamped window length is never zero
  a_win_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    win_eff != '0)
    else $error("window length zero");

endmodule

@@ hw/rtl/swm_cells.sv @@
// Sorted cell array with age tags: removes the oldest sample and inserts the new one.
module swm_cells #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swm_pkg::swm_cell_ctl_t         ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic [$clog2(WINDOW_MAX+1)-1:0] win_i,
  output logic signed [SAMPLE_WIDTH-1:0] vals_o [WINDOW_MAX],
  output logic                           result_o
);
  import swm_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int AGE_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic signed [SAMPLE_WIDTH-1:0] val_r [WINDOW_MAX];
  logic [AGE_W-1:0]               age_r [WINDOW_MAX];
  logic [FILL_W-1:0]              fill_r;
  logic [FILL_W-1:0]              fill_nxt;

  logic                  full;
  logic [AGE_W-1:0]      oldest_age;
  logic [WINDOW_MAX-1:0] vld;
  logic [WINDOW_MAX-1:0] rem;
  logic [WINDOW_MAX-1:0] kept;
  logic [WINDOW_MAX-1:0] gt;
  logic [WINDOW_MAX-1:0] below;

  // Classify every cell against the window state and the new sample
  always_comb begin
    full       = (fill_r >= win_i);
    oldest_age = AGE_W'(win_i - 1'b1);
    for (int i = 0; i < WINDOW_MAX; i++) begin
      vld[i]  = (FILL_W'(i) < fill_r);
      rem[i]  = full && vld[i] && (age_r[i] == oldest_age);
      kept[i] = vld[i] && !rem[i];
      gt[i]   = (val_r[i] > sample_i);
    end
    // a cell moves down by one if the removed cell sits below it
    for (int i = 0; i < WINDOW_MAX; i++) begin
      below[i] = |(rem & ~({WINDOW_MAX{1'b1}} << i));
    end
  end

  // Fill count after this sample and whether the window is then full
  assign fill_nxt = full ? fill_r : fill_r + 1'b1;
  assign result_o = ctl_i.step && (fill_nxt >= win_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ctl_i.flush) begin
      fill_r <= '0;
    end else if (ctl_i.step) begin
      fill_r <= fill_nxt;
    end
  end

  // Each cell picks its next entry from itself, a neighbor or the new sample
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    logic                           dn_ok;
    logic signed [SAMPLE_WIDTH-1:0] dn_val;
    logic [AGE_W-1:0]               dn_age;
    logic                           up_ok;
    logic signed [SAMPLE_WIDTH-1:0] up_val;
    logic [AGE_W-1:0]               up_age;
    logic signed [SAMPLE_WIDTH-1:0] val_nxt;
    logic [AGE_W-1:0]               age_nxt;

    // entry from the cell above, moving down past the removed one
    if (k < WINDOW_MAX - 1) begin : g_dn
      assign dn_ok  = kept[k+1] && below[k+1] && !gt[k+1];
      assign dn_val = val_r[k+1];
      assign dn_age = age_r[k+1];
    end else begin : g_no_dn
      assign dn_ok  = 1'b0;
      assign dn_val = '0;
      assign dn_age = '0;
    end

    // entry from the cell below, moving up over the new sample
    if (k > 0) begin : g_up
      assign up_ok  = kept[k-1] && !below[k-1] && gt[k-1];
      assign up_val = val_r[k-1];
      assign up_age = age_r[k-1];
    end else begin : g_no_up
      assign up_ok  = 1'b0;
      assign up_val = '0;
      assign up_age = '0;
    end

    always_comb begin
      if (kept[k] && (gt[k] == below[k])) begin
        val_nxt = val_r[k];
        age_nxt = age_r[k] + 1'b1;
      end else if (dn_ok) begin
        val_nxt = dn_val;
        age_nxt = dn_age + 1'b1;
      end else if (up_ok) begin
        val_nxt = up_val;
        age_nxt = up_age + 1'b1;
      end else begin
        val_nxt = sample_i;
        age_nxt = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.step) begin
        val_r[k] <= val_nxt;
        age_r[k] <= age_nxt;
      end
    end

    assign vals_o[k] = val_r[k];
  end

  // Fill never passes the window length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_i)
    else $error("fill count above window length");

  // A full window always holds exactly one oldest cell
  a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_i.step && full) |-> $onehot(rem))
    else $error("full window without a unique oldest cell");

  // The two lowest valid cells stay in ascending order
  a_sorted_low: assert property (@(posedge clk) disable iff (!rst_n)
    (vld[0] && (WINDOW_MAX > 1) && (fill_r > FILL_W'(1))) |-> !gt[0] || gt[WINDOW_MAX > 1 ? 1 : 0])
    else $error("cell array out of order");

endmodule

@@ hw/rtl/swm_median.sv @@
// Median pick from the cell array and the registered result stage.
module swm_median #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [SAMPLE_WIDTH-1:0]  vals_i [WINDOW_MAX],
  input  logic [$clog2(WINDOW_MAX+1)-1:0] win_i,
  input  logic                            take_i,
  output logic                            ready_o,
  swm_result_if.source                    out_ch
);
  import swm_pkg::*;

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [IDX_W-1:0]               lo_idx;
  logic [IDX_W-1:0]               hi_idx;
  logic signed [SAMPLE_WIDTH-1:0] lo_val;
  logic signed [SAMPLE_WIDTH-1:0] hi_val;
  logic signed [SAMPLE_WIDTH:0]   sum;
  logic                           pend_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH:0]   med_r;
  logic                           adv;

  // Middle cells: equal for an odd window, adjacent for an even one
  assign lo_idx = IDX_W'((win_i - 1'b1) >> 1);
  assign hi_idx = IDX_W'(win_i >> 1);
  assign lo_val = vals_i[lo_idx];
  assign hi_val = vals_i[hi_idx];
  assign sum    = {lo_val[SAMPLE_WIDTH-1], lo_val} + {hi_val[SAMPLE_WIDTH-1], hi_val};

  // Move a pending result into the output register when it is free
  assign adv     = pend_r && (!out_valid_r || out_ch.ready);
  assign ready_o = !pend_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready_o) begin
        pend_r <= take_i;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      med_r <= sum;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.median_doubled = med_r;

  // A pending result reaches an empty output register next cycle
  a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !out_valid_r) |=> out_valid_r)
    else $error("pending result not forwarded");

  // A stalled output keeps the pending result
  a_pend_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_valid_r && !out_ch.ready) |=> pend_r)
    else $error("pending result lost under stall");

endmodule

@@ sim/swm_median_checker.sv @@
// Checker for the sliding-window median filter: predicts each doubled median and compares.
module swm_median_checker #(
  parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  swm_sample_if                      in_ch,
  swm_result_if                      out_ch,
  input  logic                       cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]  cfg_wdata,
  output int                         mismatch_count,
  output int                         pending_medians
);
  import swm_pkg::*;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [SAMPLE_WIDTH:0]   median_t;

  logic [CFG_W-1:0] window_reg;
  sample_t          recent_samples[$];   // oldest first
  median_t          expected_medians[$];
  median_t          wanted;

  // Clamp the window register to the range the block supports
  function automatic int active_window(input logic [CFG_W-1:0] wsize);
    if (wsize == '0) return 1;
    if (int'(wsize) > WINDOW_MAX) return WINDOW_MAX;
    return int'(wsize);
  endfunction

  // Sort a copy of the window and double its middle
  function automatic median_t twice_median(input int w);
    sample_t ordered [WINDOW_MAX];
    sample_t key;
    int      i;
    int      j;
    for (i = 0; i < w; i++) begin
      key = recent_samples[i];
      j = i;
      while (j > 0 && ordered[j-1] > key) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = key;
    end
    if (w % 2 == 1) return median_t'(ordered[(w-1)/2]) * 2;
    return median_t'(ordered[w/2-1]) + median_t'(ordered[w/2]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      window_reg = WINDOW_RESET;
      recent_samples.delete();
      expected_medians.delete();
    end else begin
      // A window write empties the window
      if (cfg_we) begin
        window_reg = cfg_wdata;
        recent_samples.delete();
      end

      // Advance the window and predict once it is full
      if (in_ch.valid && in_ch.ready) begin
        recent_samples = {recent_samples, in_ch.sample};
        if (recent_samples.size() > active_window(window_reg))
          void'(recent_samples.pop_front());
        if (recent_samples.size() == active_window(window_reg))
          expected_medians = {expected_medians, twice_median(active_window(window_reg))};
      end

      // Compare each result item with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (expected_medians.size() == 0) begin
          $error("median_doubled: no item expected, got %0d", out_ch.median_doubled);
          mismatch_count <= mismatch_count + 1;
        end else begin
          wanted = expected_medians.pop_front();
          if (out_ch.median_doubled !== wanted) begin
            $error("median_doubled: expected %0d, got %0d", wanted, out_ch.median_doubled);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
    pending_medians <= expected_medians.size();
  end

endmodule

@@ sim/tb_sliding_window_median_top.sv @@
// Testbench top for the sliding-window median filter: stimulus, back-pressure and verdict.
module tb_sliding_window_median_top;
  import swm_pkg::*;

  localparam int SW              = SAMPLE_WIDTH_DEF;
  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_PHASES   = 12;

  typedef logic signed [SW-1:0] sample_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               hold_off_reqs;
  int               cycle_count;
  int               mismatch_count;
  int               pending_medians;

  swm_sample_if #(.SAMPLE_WIDTH(SW)) sample_ch ();
  swm_result_if #(.SAMPLE_WIDTH(SW)) median_ch ();

  sliding_window_median_top #(
    .WINDOW_MAX   (WINDOW_MAX_DEF),
    .SAMPLE_WIDTH (SW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (sample_ch),
    .out_ch    (median_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  swm_median_checker #(
    .WINDOW_MAX   (WINDOW_MAX_DEF),
    .SAMPLE_WIDTH (SW)
  ) checker_inst (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (sample_ch),
    .out_ch          (median_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_medians (pending_medians)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sliding_window_median_top verification failed");
      $finish;
    end
  end

  // Drive result ready: random idling, or a long hold-off on request
  initial begin
    int hold_off_done;
    hold_off_done = 0;
    forever begin
      if (hold_off_reqs != hold_off_done) begin
        hold_off_done = hold_off_reqs;
        median_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        median_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  // Offer one sample item, idling first at the current rate
  task automatic push_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // Hold the input until every predicted median is out and the pipe is empty
  task automatic wait_drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_medians != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [CFG_W-1:0] wsize);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= wsize;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mix full-range values, near-zero values for ties, and extremes
  function automatic sample_t pick_sample();
    case ($urandom_range(3))
      0: return sample_t'($urandom_range(8)) - sample_t'(4);
      1: begin
        case ($urandom_range(3))
          0: return sample_t'(-32768);
          1: return sample_t'(32767);
          2: return sample_t'(-1);
          default: return sample_t'(0);
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    int               phase;
    int               k;
    int               n_items;
    int               w_eff;
    logic [CFG_W-1:0] w_reg;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    hold_off_reqs    = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Window of three after reset: extremes, ties and values around zero
    push_sample(sample_t'(-32768));
    push_sample(sample_t'(32767));
    push_sample(sample_t'(-32768));
    push_sample(sample_t'(32767));
    push_sample(sample_t'(32767));
    push_sample(sample_t'(0));
    push_sample(sample_t'(-1));
    push_sample(sample_t'(1));

    // Zero acts as a window of one
    set_window('0);
    push_sample(sample_t'(5));
    push_sample(sample_t'(-32768));

    // Window of one at the top of the range
    set_window(CFG_W'(1));
    push_sample(sample_t'(32767));

    // Even window: sum of the two middle values at both extremes
    set_window(CFG_W'(2));
    push_sample(sample_t'(-32768));
    push_sample(sample_t'(-32768));
    push_sample(sample_t'(32767));
    push_sample(sample_t'(32767));

    // Random phases: receiver idles more than sender, then sender more than receiver, then neither
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: w_reg = '1;
        1: w_reg = CFG_W'(32);
        2: w_reg = CFG_W'(33);
        3: w_reg = CFG_W'(2);
        default: w_reg = CFG_W'($urandom_range(1, 12));
      endcase
      send_idle_pct = (phase < 4) ? 34 : (phase < 8) ? 59 : 0;
      recv_idle_pct = (phase < 4) ? 59 : (phase < 8) ? 34 : 0;
      set_window(w_reg);
      w_eff   = (int'(w_reg) > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : int'(w_reg);
      n_items = w_eff + $urandom_range(25, 50);
      for (k = 0; k < n_items; k++) begin
        // Stall the receiver while the sender keeps offering
        if ((phase == 4 || phase == 8) && k == w_eff + 5) hold_off_reqs++;
        push_sample(pick_sample());
      end
    end

    wait_drain();
    if (mismatch_count == 0) begin
      $display("sliding_window_median_top verification clean");
    end else begin
      $display("sliding_window_median_top verification failed");
    end
    $finish;
  end

endmodule
